// ----- hdl/png_scanline_unfilter_defines.svh -----
// Assertion macros for the PNG scanline unfilter block.
// Included by the port checker; depends on nothing else.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/psu_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter block.
// No dependencies; imported by the top level, the line buffer and the testbench.
package psu_pkg;

   localparam int PIX_W           = 8;
   localparam int COL_W           = 15;
   localparam int ROW_W           = 13;
   localparam int CFG_W           = 14;
   localparam int CSR_IDX_W       = 1;
   localparam int LANES           = 4;
   localparam int LANE_W          = 2;
   localparam int BYTES_PER_PIXEL = 4;
   localparam int BPP_SHIFT       = 2;
   localparam int HEIGHT_LIMIT    = 8192;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   localparam logic [PIX_W-1:0] FILT_MAX = 8'd4;

   // Item waiting in the stage that meets the line buffer read data
   typedef struct packed {
      logic [PIX_W-1:0]  pix;
      logic [LANE_W-1:0] lane;
      filter_type        filter;
      logic              above;
      logic              eor;
      logic              eoi;
      logic              bad;
   } stage_type;

   // Paeth predictor: pick the neighbour closest to a + b - c
   function automatic logic [PIX_W-1:0] paeth_pick(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b,
                                                    input logic [PIX_W-1:0] c);
      logic signed [9:0] sa;
      logic signed [9:0] sb;
      logic signed [9:0] sc;
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic        [9:0] pa;
      logic        [9:0] pb;
      logic        [9:0] pc;
      sa = signed'({2'b00, a});
      sb = signed'({2'b00, b});
      sc = signed'({2'b00, c});
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

endpackage

// ----- hdl/psu_line_buf.sv -----
// Line buffer holding the previous reconstructed row, one byte per entry.
// One write and one registered read per cycle; depends on psu_pkg.
module psu_line_buf #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [psu_pkg::PIX_W-1:0]  wr_data,
   output logic [psu_pkg::PIX_W-1:0]  rd_data
);
   import psu_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // Write the reconstructed byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read with forwarding of a same-cycle write to the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/png_scanline_unfilter.sv -----
// PNG scanline filter reconstruction for 8-bit RGBA, top level.
// Depends on psu_pkg and psu_line_buf.
//
// Takes one inflated byte per transfer: the first byte of each row is the
// filter type, the next image_width*4 bytes are filtered samples, each of
// which yields one reconstructed byte. The block sustains one byte per cycle
// in both directions while rsp_tready stays high; a result passes the stage
// that meets the line buffer read data, then the response register. The
// line buffer is a memory of MAX_WIDTH*4 bytes with one read and one write
// port. It is not cleared after reset: row 0 never uses its read data. A
// filter type above 4 gives one result with bad_filter set and then drops
// input until a transfer with start_of_image. Width and height writes take
// effect at once and should be made between images.
module png_scanline_unfilter #(
   parameter int MAX_WIDTH = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   // request stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] stream_byte
   input  logic [0:0]                  req_tuser,   // [0] start_of_image
   // response stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] pixel_byte
   output logic                        rsp_tlast,   // end_of_row
   output logic [1:0]                  rsp_tuser,   // [0] end_of_image, [1] bad_filter
   // configuration writes
   input  logic                        csr_we,
   input  logic [psu_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [psu_pkg::CFG_W-1:0]   csr_wdata
);
   import psu_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;
   localparam int AW         = $clog2(LINE_DEPTH);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int SW         = WW + BPP_SHIFT;
   localparam int WCMP_W     = (WW > CFG_W) ? WW : CFG_W;
   localparam int XW         = (COL_W > AW + 1) ? COL_W : AW + 1;
   localparam int CMP_W      = (SW > COL_W) ? SW : COL_W;

   // configuration, stored already clamped
   logic [SW-1:0]     stride_ff, stride_in;
   logic [CFG_W-1:0]  rows_ff, rows_in;

   // row control state
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   filter_type        filter_ff, filter_in;
   logic              await_ff, await_in;
   logic              halted_ff, halted_in;

   // neighbour bytes per lane
   logic [PIX_W-1:0]  left_ff [LANES];
   logic [PIX_W-1:0]  upleft_ff [LANES];

   // stage waiting on line buffer data
   logic              p1_valid_ff;
   stage_type         p1_ff, p1_in;
   logic [AW-1:0]     p1_addr_ff, p1_addr_in;
   logic              load_p1;

   // response register
   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_data_ff;
   logic              rsp_last_ff;
   logic [1:0]        rsp_user_ff;

   // handshake
   logic              accept, start, out_free, p1_adv;
   logic [PIX_W-1:0]  in_byte;

   // stage A scratch
   logic              halted_eff, await_eff;
   logic [ROW_W-1:0]  row_eff;
   logic [COL_W-1:0]  col_next;
   logic [XW-1:0]     x_wide;
   logic              eor, eoi;

   // config scratch
   logic [WCMP_W-1:0] cfg_w;
   logic [WW-1:0]     width_clamped;

   // stage B datapath
   logic [PIX_W-1:0]  rd_data, nb_a, nb_b, nb_c, pred, recon;
   logic [PIX_W:0]    avg_sum;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign p1_adv     = p1_valid_ff && out_free;
   assign req_tready = !p1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign start      = req_tuser[0];
   assign in_byte    = req_tdata;

   // Clamp register writes into their usable range
   always_comb begin
      cfg_w     = WCMP_W'(csr_wdata);
      stride_in = stride_ff;
      rows_in   = rows_ff;
      if (cfg_w == '0) begin
         width_clamped = WW'(1);
      end else if (cfg_w > WCMP_W'(MAX_WIDTH)) begin
         width_clamped = WW'(MAX_WIDTH);
      end else begin
         width_clamped = WW'(cfg_w);
      end
      if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH: begin
               stride_in = SW'(width_clamped) << BPP_SHIFT;
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_wdata == '0) begin
                  rows_in = CFG_W'(1);
               end else if (csr_wdata > CFG_W'(HEIGHT_LIMIT)) begin
                  rows_in = CFG_W'(HEIGHT_LIMIT);
               end else begin
                  rows_in = csr_wdata;
               end
            end
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   // Stage A: decode the byte, advance row control, queue a sample or error
   always_comb begin
      halted_eff = start ? 1'b0 : halted_ff;
      await_eff  = start ? 1'b1 : await_ff;
      row_eff    = start ? '0 : row_ff;
      col_next   = col_ff + COL_W'(1);
      eor        = (CMP_W'(col_next) >= CMP_W'(stride_ff)) || (col_next == '0);
      eoi        = ({1'b0, row_eff} + CFG_W'(1)) >= rows_ff;
      x_wide     = XW'(col_ff);
      if (x_wide >= XW'(LINE_DEPTH)) begin
         x_wide = XW'(LINE_DEPTH - 1);
      end

      halted_in  = halted_ff;
      await_in   = await_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      filter_in  = filter_ff;
      load_p1    = 1'b0;
      p1_addr_in = AW'(x_wide);
      p1_in      = '{pix: in_byte, lane: x_wide[LANE_W-1:0], filter: filter_ff,
                     above: (row_eff != '0), eor: eor, eoi: eor && eoi, bad: 1'b0};

      if (accept) begin
         halted_in = halted_eff;
         await_in  = await_eff;
         row_in    = row_eff;
         if (start) begin
            col_in = '0;
         end
         if (!halted_eff) begin
            priority if (await_eff && in_byte > FILT_MAX) begin
               halted_in = 1'b1;
               load_p1   = 1'b1;
               p1_in     = '{pix: '0, lane: '0, filter: FILT_NONE, above: 1'b0,
                             eor: 1'b0, eoi: 1'b0, bad: 1'b1};
            end else if (await_eff) begin
               filter_in = filter_type'(in_byte[2:0]);
               await_in  = 1'b0;
            end else begin
               load_p1 = 1'b1;
               col_in  = col_next;
               if (eor) begin
                  col_in   = '0;
                  await_in = 1'b1;
                  row_in   = eoi ? '0 : row_eff + ROW_W'(1);
               end
            end
         end
      end
   end

   psu_line_buf #(
      .DEPTH (LINE_DEPTH),
      .AW    (AW)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (load_p1),
      .rd_addr (p1_addr_in),
      .wr_en   (p1_adv && !p1_ff.bad),
      .wr_addr (p1_addr_ff),
      .wr_data (recon),
      .rd_data (rd_data)
   );

   // Stage B: predict from the neighbours and add the filtered sample
   always_comb begin
      nb_a    = left_ff[p1_ff.lane];
      nb_c    = upleft_ff[p1_ff.lane];
      nb_b    = p1_ff.above ? rd_data : '0;
      avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
      unique case (p1_ff.filter)
         FILT_NONE:  pred = '0;
         FILT_SUB:   pred = nb_a;
         FILT_UP:    pred = nb_b;
         FILT_AVG:   pred = avg_sum[PIX_W:1];
         FILT_PAETH: pred = paeth_pick(nb_a, nb_b, nb_c);
         default:    pred = '0;
      endcase
      recon = p1_ff.pix + pred;
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff   <= SW'(BYTES_PER_PIXEL);
         rows_ff     <= CFG_W'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         filter_ff   <= FILT_NONE;
         await_ff    <= 1'b1;
         halted_ff   <= 1'b0;
         p1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stride_ff <= stride_in;
         rows_ff   <= rows_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         filter_ff <= filter_in;
         await_ff  <= await_in;
         halted_ff <= halted_in;
         if (load_p1) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_adv) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Neighbour registers: clear on reset, on a new image or at the end of a row
   always_ff @(posedge clock) begin
      if (reset || (accept && start) || (p1_adv && !p1_ff.bad && p1_ff.eor)) begin
         for (int i = 0; i < LANES; i++) begin
            left_ff[i]   <= '0;
            upleft_ff[i] <= '0;
         end
      end else if (p1_adv && !p1_ff.bad) begin
         left_ff[p1_ff.lane]   <= recon;
         upleft_ff[p1_ff.lane] <= nb_b;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load_p1) begin
         p1_ff      <= p1_in;
         p1_addr_ff <= p1_addr_in;
      end
      if (p1_adv) begin
         rsp_data_ff <= recon;
         rsp_last_ff <= p1_ff.eor;
         rsp_user_ff <= {p1_ff.bad, p1_ff.eoi};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- hdl/psu_checker.sv -----
// Port-level checks for the PNG scanline unfilter, bound to the top level.
// Depends on png_scanline_unfilter_defines.svh for the assertion macros.
`include "png_scanline_unfilter_defines.svh"

module psu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);

   // hold a stalled response transfer
   `PSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled response changed")

   // an error result carries no pixel and no markers
   `PSU_ASSERT_NOW(a_bad_clean, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata == 8'd0 && !rsp_tlast && !rsp_tuser[0], "error result carries data")

   // the last byte of the image also ends its row
   `PSU_ASSERT_NOW(a_eoi_eor, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast, "end of image without end of row")

   // a fresh result follows an earlier request transfer
   `PSU_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "result without a request transfer")

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);

// ----- sim/tb_png_scanline_unfilter.sv -----
// Testbench for png_scanline_unfilter: directed and random RGBA8 scanline streams
// with random stalls, checked against an in-bench model of filter reconstruction.
// Depends on psu_pkg and the png_scanline_unfilter RTL.
module tb_png_scanline_unfilter;
   import psu_pkg::*;

   localparam int WIDTH_MAX     = 8192;
   localparam int LINE_BYTES    = WIDTH_MAX * BYTES_PER_PIXEL;
   localparam int STALL_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 8;
   localparam int RANDOM_ITEMS  = 1650;
   localparam int CALM_ITEMS    = 200;
   localparam int EXTREME_ROWS  = 4;
   localparam int EXTREME_BYTES = 200;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             eor;
      logic             eoi;
      logic             bad;
   } pixel_out_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;   // [7:0] stream_byte
   logic [0:0]           req_tuser = '0;   // [0] start_of_image
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;        // [7:0] pixel_byte
   logic                 rsp_tlast;        // end_of_row
   logic [1:0]           rsp_tuser;        // [0] end_of_image, [1] bad_filter
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // Model state of the unfilter
   logic [7:0]   line_mem [LINE_BYTES];
   logic [7:0]   left_px [LANES];
   logic [7:0]   upleft_px [LANES];
   logic [14:0]  col_pos;
   logic [12:0]  row_pos;
   filter_type   cur_filter;
   bit           awaiting_filter;
   bit           halted_img;
   logic [13:0]  width_reg;
   logic [13:0]  height_reg;

   pixel_out_type expected_pixels [$];
   int unsigned  live_items = 0;
   int unsigned  mismatches = 0;
   bit           idle_on = 1'b1;
   int unsigned  rsp_hold = 0;

   png_scanline_unfilter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic int unsigned clamp_cfg(input logic [13:0] v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic int unsigned row_bytes();
      return clamp_cfg(width_reg, WIDTH_MAX) * BYTES_PER_PIXEL;
   endfunction

   function automatic int unsigned image_rows();
      return clamp_cfg(height_reg, HEIGHT_LIMIT);
   endfunction

   // Neighbour nearest to a + b - c, ties going a, then b
   function automatic logic [7:0] paeth_choice(input int a, input int b, input int c);
      int da;
      int db;
      int dc;
      da = b - c;
      db = a - c;
      dc = a + b - 2 * c;
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return 8'(a);
      return (db <= dc) ? 8'(b) : 8'(c);
   endfunction

   task automatic clear_row_state();
      for (int i = 0; i < LANES; i++) begin
         left_px[i]   = 8'h00;
         upleft_px[i] = 8'h00;
      end
      col_pos = '0;
      awaiting_filter = 1'b1;
   endtask

   task automatic reset_model();
      width_reg  = 14'd1;
      height_reg = 14'd1;
      for (int i = 0; i < LINE_BYTES; i++) line_mem[i] = 8'h00;
      clear_row_state();
      row_pos    = '0;
      cur_filter = FILT_NONE;
      halted_img = 1'b0;
   endtask

   // Work out the result, if any, of one accepted byte
   task automatic unfilter_predict(input logic [7:0] sample, input bit sof);
      logic [14:0] x;
      logic [1:0]  lane;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  pred;
      logic [8:0]  avg;
      pixel_out_type res;
      if (sof) begin
         halted_img = 1'b0;
         row_pos = '0;
         clear_row_state();
      end
      if (halted_img) return;
      live_items++;
      if (awaiting_filter) begin
         if (sample > FILT_MAX) begin
            halted_img = 1'b1;
            res = '{8'h00, 1'b0, 1'b0, 1'b1};
            expected_pixels = {expected_pixels, res};
         end else begin
            cur_filter = filter_type'(sample[2:0]);
            awaiting_filter = 1'b0;
         end
         return;
      end
      x    = col_pos;
      lane = x[1:0];
      a    = left_px[lane];
      b    = (row_pos != 0) ? line_mem[x] : 8'h00;
      c    = upleft_px[lane];
      case (cur_filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG: begin
            avg  = {1'b0, a} + {1'b0, b};
            pred = avg[8:1];
         end
         FILT_PAETH: pred = paeth_choice(a, b, c);
         default:    pred = 8'h00;
      endcase
      res.pix = sample + pred;
      res.eor = 1'b0;
      res.eoi = 1'b0;
      res.bad = 1'b0;
      line_mem[x]     = res.pix;
      left_px[lane]   = res.pix;
      upleft_px[lane] = b;
      col_pos = col_pos + 15'd1;
      // Row ends at the stride or when the column counter wraps
      if (col_pos >= row_bytes() || col_pos == 0) begin
         res.eor = 1'b1;
         if (row_pos + 1 >= image_rows()) begin
            res.eoi = 1'b1;
            row_pos = '0;
         end else begin
            row_pos = row_pos + 13'd1;
         end
         clear_row_state();
      end
      expected_pixels = {expected_pixels, res};
   endtask

   // Send one byte; entered and left at a falling edge
   task automatic push_byte(input logic [7:0] value, input bit sof);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tuser  = sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      unfilter_predict(value, sof);
      @(negedge clock);
   endtask

   task automatic send_row(input bit sof, input logic [7:0] filt, input int unsigned nbytes);
      push_byte(filt, sof);
      repeat (nbytes) push_byte(8'($urandom), 1'b0);
   endtask

   task automatic send_image(input bit sof);
      for (int unsigned r = 0; r < image_rows(); r++) begin
         send_row(sof && r == 0, 8'($urandom_range(FILT_NONE, FILT_PAETH)), row_bytes());
      end
   endtask

   // Hold the input until every result is out and the pipeline is empty
   task automatic settle();
      req_tvalid = 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [13:0] value);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
   endtask

   task automatic configure(input logic [13:0] w, input logic [13:0] h);
      settle();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
   endtask

   function automatic logic [7:0] edge_sample(input int i);
      case (i % 6)
         0: return 8'hFF;
         1: return 8'h00;
         2: return 8'hFF;
         3: return 8'h01;
         4: return 8'h80;
         default: return 8'h7F;
      endcase
   endfunction

   // One row per filter type, samples at the byte extremes
   task automatic test_each_filter();
      filter_type order [5];
      order = '{FILT_NONE, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH};
      configure(14'd1, 14'd5);
      for (int r = 0; r < 5; r++) begin
         push_byte(8'(order[r]), r == 0);
         for (int j = 0; j < BYTES_PER_PIXEL; j++) push_byte(edge_sample(r * 4 + j), 1'b0);
      end
   endtask

   // Bad filter bytes, dropped input, restart mid-row, wrap after the last row
   task automatic test_bad_filter();
      configure(14'd1, 14'd2);
      push_byte(8'(FILT_MAX + 1), 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'(FILT_NONE), 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'(FILT_UP), 1'b1);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hA5, 1'b0);
      send_row(1'b1, 8'(FILT_SUB), row_bytes());
      push_byte(8'h80, 1'b0);
      push_byte(8'(FILT_NONE), 1'b0);
      send_image(1'b1);
      send_image(1'b0);
   endtask

   // Register values at and beyond both ends of their ranges
   task automatic test_register_extremes();
      configure(14'd0, 14'd0);
      send_image(1'b1);
      send_image(1'b0);
      // tall image: the first rows only, none of which may end the image
      configure(14'd0, 14'h3FFF);
      for (int r = 0; r < EXTREME_ROWS; r++) begin
         send_row(r == 0, 8'($urandom_range(FILT_NONE, FILT_PAETH)), row_bytes());
      end
      // widest row, cut short
      configure(14'h3FFF, 14'd1);
      send_row(1'b1, 8'($urandom_range(FILT_NONE, FILT_PAETH)), EXTREME_BYTES);
   endtask

   // Mostly whole images with random content; some cut short or with bad filters
   task automatic test_random_images();
      int unsigned base;
      int unsigned w;
      int unsigned h;
      int unsigned k;
      int unsigned kind;
      bit          image_done;
      base = live_items;
      while (live_items - base < RANDOM_ITEMS) begin
         idle_on = (live_items - base < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 64) : $urandom_range(0, 4);
         h = $urandom_range(0, 4);
         configure(14'(w), 14'(h));
         image_done = 1'b0;
         repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 9);
            k = $urandom_range(0, image_rows() - 1);
            if (kind < 7) begin
               send_image(!(image_done && kind == 0));
               image_done = 1'b1;
            end else begin
               for (int unsigned r = 0; r < k; r++) begin
                  send_row(r == 0, 8'($urandom_range(FILT_NONE, FILT_PAETH)), row_bytes());
               end
               if (kind == 7) begin
                  // cut the row short
                  send_row(k == 0, 8'($urandom_range(FILT_NONE, FILT_PAETH)),
                           $urandom_range(0, row_bytes() - 1));
               end else begin
                  // bad filter, then bytes that are dropped
                  push_byte(8'($urandom_range(FILT_MAX + 1, 255)), k == 0);
                  repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
               end
               image_done = 1'b0;
            end
         end
      end
   endtask

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      pixel_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected result pixel %02h eor %0b eoi %0b bad %0b",
                                    rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[1]));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata !== want.pix || rsp_tlast !== want.eor ||
                rsp_tuser[0] !== want.eoi || rsp_tuser[1] !== want.bad) begin
               note_mismatch($sformatf("got %02h/%0b/%0b/%0b, want %02h/%0b/%0b/%0b",
                                       rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[1],
                                       want.pix, want.eor, want.eoi, want.bad));
            end
         end
      end
   end

   // Result side back-pressure in bursts
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready = 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         rsp_hold = $urandom_range(0, 15);
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // End the run if nothing moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_each_filter();
      test_bad_filter();
      test_register_extremes();
      test_random_images();
      idle_on = 1'b0;
      req_tvalid = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
